// ===== sv/wsld_pkg.sv =====
package wsld_pkg;

  localparam int unsigned SIM_W   = 17;
  localparam int unsigned THR_W   = 17;
  localparam int unsigned MIN_W   = 4;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned IN_FW   = 16;
  localparam int unsigned NFEAT   = 4;
  localparam int unsigned EXP_N   = 11;
  localparam int unsigned DQ4_W   = 11;
  localparam int unsigned RAD_W   = 22;
  localparam int unsigned ACC_W   = 33;
  localparam int unsigned EXPF_W  = 32;
  localparam int unsigned CNT_SAT = 15;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_MIN_MATCH = 1'b1
  } cfg_reg_e;

  localparam logic [THR_W-1:0] THR_RESET = 17'd58982;
  localparam logic [MIN_W-1:0] MIN_RESET = 4'd3;

  // exp(-2^k/160) in Q0.32, one entry per bit of the Q4 distance.
  function automatic logic [EXPF_W-1:0] expf(input logic [3:0] k);
    logic [EXPF_W-1:0] r;
    case (k)
      4'd0:    r = 32'd4268207462;
      4'd1:    r = 32'd4241614355;
      4'd2:    r = 32'd4188924176;
      4'd3:    r = 32'd4085499269;
      4'd4:    r = 32'd3886247119;
      4'd5:    r = 32'd3516421809;
      4'd6:    r = 32'd2879002676;
      4'd7:    r = 32'd1929853206;
      4'd8:    r = 32'd867138942;
      4'd9:    r = 32'd175072333;
      4'd10:   r = 32'd7136334;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/wsld_if.sv =====
interface wsld_in_if;
  import wsld_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic             sample_valid;
  logic [IN_FW-1:0] cpu_load;
  logic [IN_FW-1:0] memory_used;
  logic [IN_FW-1:0] disk_read_amount;
  logic [IN_FW-1:0] disk_write_amount;

  modport source (output valid, command, sample_valid, cpu_load, memory_used,
                  disk_read_amount, disk_write_amount, input ready);
  modport sink (input valid, command, sample_valid, cpu_load, memory_used,
                disk_read_amount, disk_write_amount, output ready);
endinterface

interface wsld_out_if;
  import wsld_pkg::*;
  logic             valid;
  logic             ready;
  logic             loop_found;
  logic [3:0]       match_count;
  logic [SIM_W-1:0] confidence;

  modport source (output valid, loop_found, match_count, confidence, input ready);
  modport sink (input valid, loop_found, match_count, confidence, output ready);
endinterface

// ===== sv/wsld_sim_unit.sv =====
module wsld_sim_unit
  import wsld_pkg::*;
#(
  parameter int unsigned FEATURE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [NFEAT*FEATURE_BITS-1:0] feat_a_i,
  input  logic [NFEAT*FEATURE_BITS-1:0] feat_b_i,
  output logic                         done_o,
  output logic [SIM_W-1:0]             sim_o
);

  localparam int unsigned SUM_W = 2 * FEATURE_BITS + 2;

  typedef enum logic [4:0] {
    SI_IDLE = 5'b00001,
    SI_SQ   = 5'b00010,
    SI_SQRT = 5'b00100,
    SI_EXP  = 5'b01000,
    SI_DONE = 5'b10000
  } si_state_e;

  si_state_e          state_q, state_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [RAD_W-1:0]   rad_q, rad_d;
  logic [RAD_W-1:0]   res_q, res_d;
  logic [RAD_W-2:0]   bit_q, bit_d;
  logic [ACC_W-1:0]   acc_q, acc_d;

  logic [FEATURE_BITS-1:0] fa, fb, diff;
  logic [ACC_W-1:0]        mul_a;
  logic [EXPF_W-1:0]       mul_b;
  logic [ACC_W+EXPF_W-1:0] prod;
  logic [RAD_W-1:0]        trial;
  logic [ACC_W:0]          rnd;

  // One multiplier serves both the squared differences and the exponential steps.
  always_comb begin
    fa   = feat_a_i[cnt_q[1:0]*FEATURE_BITS +: FEATURE_BITS];
    fb   = feat_b_i[cnt_q[1:0]*FEATURE_BITS +: FEATURE_BITS];
    diff = (fa > fb) ? (fa - fb) : (fb - fa);
    if (state_q == SI_EXP) begin
      mul_a = acc_q;
      mul_b = expf(cnt_q);
    end else begin
      mul_a = ACC_W'(diff);
      mul_b = EXPF_W'(diff);
    end
    prod  = mul_a * mul_b;
    trial = res_q + RAD_W'(bit_q);
    rnd   = (ACC_W+1)'(acc_q) + (ACC_W+1)'(33'd32768);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    rad_d   = rad_q;
    res_d   = res_q;
    bit_d   = bit_q;
    acc_d   = acc_q;
    case (state_q)
      SI_IDLE: begin
        if (start_i) begin
          state_d = SI_SQ;
          cnt_d   = '0;
          sum_d   = '0;
        end
      end
      SI_SQ: begin
        sum_d = sum_q + prod[SUM_W-1:0];
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(NFEAT - 1)) begin
          cnt_d = '0;
          // A distance of 128 or more (sum of squares >= 2^14) gives zero similarity.
          if (|sum_d[SUM_W-1:14]) begin
            acc_d   = '0;
            state_d = SI_DONE;
          end else begin
            rad_d   = {sum_d[13:0], 8'd0};
            res_d   = '0;
            bit_d   = {1'b1, {(RAD_W-2){1'b0}}};
            state_d = SI_SQRT;
          end
        end
      end
      SI_SQRT: begin
        if (rad_q >= trial) begin
          rad_d = rad_q - trial;
          res_d = (res_q >> 1) + RAD_W'(bit_q);
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(DQ4_W - 1)) begin
          cnt_d   = '0;
          acc_d   = {1'b1, {(ACC_W-1){1'b0}}};
          state_d = SI_EXP;
        end
      end
      SI_EXP: begin
        if (res_q[cnt_q]) begin
          acc_d = prod[ACC_W+EXPF_W-1:EXPF_W] + ACC_W'(prod[EXPF_W-1]);
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(EXP_N - 1)) begin
          state_d = SI_DONE;
        end
      end
      SI_DONE: begin
        state_d = SI_IDLE;
      end
      default: state_d = SI_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SI_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    rad_q <= rad_d;
    res_q <= res_d;
    bit_q <= bit_d;
    acc_q <= acc_d;
  end

  // The product is final in the done state; a far sample leaves it at zero.
  assign done_o = (state_q == SI_DONE);
  assign sim_o  = SIM_W'(rnd[ACC_W:16]);

endmodule

// ===== sv/wsld_divider.sv =====
module wsld_divider
  import wsld_pkg::*;
#(
  parameter int unsigned DIVD_W = 21,
  parameter int unsigned DIVS_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DIVD_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIVS_W:0]   rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W:0]   trial;

  // Restoring division, one quotient bit a cycle.
  assign trial = {rem_q[DIVS_W-1:0], quo_q[DIVD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (trial >= (DIVS_W+1)'(divisor_i)) begin
        rem_q <= trial - (DIVS_W+1)'(divisor_i);
        quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/window_similarity_loop_detector.sv =====
// From the input transfer to a registered result: a clear goes straight to the output; an add
// scans the window, squaring the differences for each compared slot and adding the square root
// and exponential steps where its distance is below 128, then divides for the mean when a loop has matches.
// Throughput: one item at a time; the input is not ready until the result is registered.
// The shared similarity unit (one multiplier, square root and exponential steps) sets this.
// Reset: asynchronous, active low; empties the window, pointer to zero, registers to defaults.
module window_similarity_loop_detector
  import wsld_pkg::*;
#(
  parameter int unsigned WINDOW       = 16,
  parameter int unsigned FEATURE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  wsld_in_if.sink          in_i,
  wsld_out_if.source       out_o
);

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned TOT_W  = SIM_W + CNT_W;
  localparam int unsigned SMP_W  = NFEAT * FEATURE_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_START = 7'b0000100,
    S_WAIT  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_DWAIT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e             state_q;
  logic [THR_W-1:0]   thr_q;
  logic [MIN_W-1:0]   min_q;
  logic [WINDOW-1:0]  slot_valid_q;
  logic [IDX_W-1:0]   wp_q, pos_q, idx_q;
  logic               sv_q;
  logic [SMP_W-1:0]   feat_q, rdata_q;
  logic [SMP_W-1:0]   mem_q [WINDOW];
  logic [CNT_W-1:0]   count_q;
  logic [TOT_W-1:0]   total_q;
  logic               loop_q;
  logic [SIM_W-1:0]   conf_q;
  logic               out_valid_q, out_loop_q;
  logic [3:0]         out_count_q;
  logic [SIM_W-1:0]   out_conf_q;

  logic               in_xfer, last_idx, slot_live, loop_now;
  logic [SMP_W-1:0]   in_feat;
  logic               sim_start, sim_done, div_start, div_done;
  logic [SIM_W-1:0]   sim;
  logic [TOT_W-1:0]   quotient;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign in_feat   = {in_i.disk_write_amount[FEATURE_BITS-1:0],
                      in_i.disk_read_amount[FEATURE_BITS-1:0],
                      in_i.memory_used[FEATURE_BITS-1:0],
                      in_i.cpu_load[FEATURE_BITS-1:0]};
  assign last_idx  = (idx_q == IDX_W'(WINDOW - 1));
  assign slot_live = (idx_q != pos_q) && slot_valid_q[idx_q];
  assign loop_now  = ({{(CNT_W > MIN_W ? CNT_W - MIN_W : 0){1'b0}}, min_q} <=
                      (CNT_W > MIN_W ? CNT_W : MIN_W)'(count_q));
  assign sim_start = (state_q == S_START);
  assign div_start = (state_q == S_DIV) && loop_now && (count_q != '0);

  wsld_sim_unit #(
    .FEATURE_BITS(FEATURE_BITS)
  ) u_sim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sim_start),
    .feat_a_i(rdata_q),
    .feat_b_i(feat_q),
    .done_o  (sim_done),
    .sim_o   (sim)
  );

  wsld_divider #(
    .DIVD_W(TOT_W),
    .DIVS_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(total_q),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer && !in_i.command) begin
      mem_q[wp_q] <= in_feat;
    end
    rdata_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      min_q <= MIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        REG_MIN_MATCH: min_q <= cfg_data_i[MIN_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_valid_q <= '0;
      wp_q         <= '0;
      pos_q        <= '0;
      idx_q        <= '0;
      sv_q         <= 1'b0;
      count_q      <= '0;
      total_q      <= '0;
      loop_q       <= 1'b0;
      conf_q       <= '0;
      out_valid_q  <= 1'b0;
      out_loop_q   <= 1'b0;
      out_count_q  <= '0;
      out_conf_q   <= '0;
      feat_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            count_q <= '0;
            total_q <= '0;
            loop_q  <= 1'b0;
            conf_q  <= '0;
            if (in_i.command) begin
              slot_valid_q <= '0;
              state_q      <= S_OUT;
            end else begin
              slot_valid_q[wp_q] <= in_i.sample_valid;
              pos_q   <= wp_q;
              sv_q    <= in_i.sample_valid;
              feat_q  <= in_feat;
              idx_q   <= '0;
              wp_q    <= (wp_q == IDX_W'(WINDOW - 1)) ? '0 : wp_q + IDX_W'(1);
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (slot_live && sv_q) begin
            state_q <= S_START;
          end else begin
            // An empty new sample scores zero against each valid slot.
            if (slot_live && (thr_q == '0)) begin
              count_q <= count_q + CNT_W'(1);
            end
            if (last_idx) begin
              state_q <= S_DIV;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (sim_done) begin
            if (sim >= thr_q) begin
              count_q <= count_q + CNT_W'(1);
              total_q <= total_q + TOT_W'(sim);
            end
            if (last_idx) begin
              state_q <= S_DIV;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          loop_q <= loop_now;
          if (div_start) begin
            state_q <= S_DWAIT;
          end else begin
            conf_q  <= '0;
            state_q <= S_OUT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            conf_q  <= quotient[SIM_W-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_loop_q  <= loop_q;
            out_count_q <= (count_q > CNT_W'(CNT_SAT)) ? 4'(CNT_SAT) : 4'(count_q);
            out_conf_q  <= conf_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.loop_found  = out_loop_q;
  assign out_o.match_count = out_count_q;
  assign out_o.confidence  = out_conf_q;

`ifndef NO_ASSERTIONS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("input still ready after a transfer");

  a_no_loop_zero_conf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.loop_found) |-> (out_o.confidence == '0))
    else $error("confidence without a loop");

  a_loop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.loop_found) |-> (out_o.match_count >= min_q))
    else $error("loop reported below the alert minimum");

  a_sim_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sim_done |-> (state_q == S_WAIT))
    else $error("similarity result outside a wait");
`endif

endmodule
